@@ rtl/bwts_pkg.sv @@
// Shared constants, types and helpers for the bilinear wrap texture sampler.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bwts_pkg;

   // texel store geometry
   localparam int unsigned ADDR_W     = 16;
   localparam int unsigned MAX_TEXELS = 1 << ADDR_W;
   localparam int unsigned CHAN_W     = 16;
   localparam int unsigned NUM_CHAN   = 3;
   localparam int unsigned NUM_TAPS   = 4;

   // image size registers
   localparam int unsigned DIM_W   = 9;
   localparam int unsigned DIM_MAX = 256;
   localparam int unsigned CELL_W  = 8;             // column / row index bits

   // coordinate and weight formats
   localparam int unsigned FRAC_W = 16;
   localparam int unsigned WGT_W  = FRAC_W + 1;     // weights span 0..1.0 inclusive
   localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_W;

   // divide by three: floor(x * RECIP / 2^SHIFT) is exact for x < 2^SHIFT
   localparam int unsigned SUM_W           = CHAN_W + 2;
   localparam int unsigned RECIP_W         = 18;
   localparam logic [RECIP_W-1:0] ONE_THIRD_RECIP = 18'd174763;
   localparam int unsigned ONE_THIRD_SHIFT = 19;

   // configuration port
   localparam int unsigned PADDR_W    = 3;
   localparam int unsigned PDATA_W    = 32;
   localparam int unsigned REG_SEL_BIT = 2;
   localparam logic REG_IDX_WIDTH  = 1'b0;
   localparam logic REG_IDX_HEIGHT = 1'b1;

   // request opcodes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // channel 0 red, 1 green, 2 blue
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] texel_type;

   // request after address generation, entering the texel store
   typedef struct packed {
      logic                             op;
      logic [ADDR_W-1:0]                wr_addr;
      texel_type                        wr_texel;
      logic [NUM_TAPS-1:0][ADDR_W-1:0]  tap_addr;   // r0c0, r0c1, r1c0, r1c1
      logic [FRAC_W-1:0]                fu;
      logic [FRAC_W-1:0]                fv;
   } samp_cmd_type;

   // zero reads as one, anything above the maximum as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (d > DIM_W'(DIM_MAX)) begin
         r = DIM_W'(DIM_MAX);
      end else begin
         r = d;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/bwts_addr_gen.sv @@
// Address generation: wraps u and 1-v, scales by image size, forms the four
// neighbor addresses and the in-texel fractions. Two stages. Uses bwts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bwts_addr_gen import bwts_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic                 in_op,
   input  wire logic [ADDR_W-1:0]    in_index,
   input  wire texel_type            in_texel,
   input  wire logic [FRAC_W-1:0]    in_u_frac,
   input  wire logic [FRAC_W-1:0]    in_v_frac,
   input  wire logic [DIM_W-1:0]     dim_w,
   input  wire logic [DIM_W-1:0]     dim_h,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output samp_cmd_type              out_cmd
);

   localparam int unsigned POS_W  = FRAC_W + DIM_W;
   localparam int unsigned ROWB_W = CELL_W + DIM_W;

   // stage 1: scaled positions
   logic                 v1_ff, v1_in;
   logic                 op1_ff;
   logic [ADDR_W-1:0]    idx1_ff;
   texel_type            texel1_ff;
   logic [POS_W-1:0]     pu1_ff, pu_in;
   logic [POS_W-1:0]     pv1_ff, pv_in;
   logic [FRAC_W-1:0]    vf;

   // stage 2: addresses
   logic                 v2_ff, v2_in;
   samp_cmd_type         cmd2_ff, cmd2_in;

   logic                 rdy1, rdy2;
   logic [CELL_W-1:0]    col0, col1, row0, row1;
   logic [DIM_W-1:0]     col0_inc, row0_inc;
   logic [ROWB_W-1:0]    base0, base1;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // 1 - v wrapped into [0,1) is the two's complement of the fraction
   assign vf    = '0 - in_v_frac;
   assign pu_in = POS_W'(in_u_frac) * POS_W'(dim_w);
   assign pv_in = POS_W'(vf) * POS_W'(dim_h);
   assign v1_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         op1_ff    <= in_op;
         idx1_ff   <= in_index;
         texel1_ff <= in_texel;
         pu1_ff    <= pu_in;
         pv1_ff    <= pv_in;
      end
   end

   // pu < 2^24 since the fraction is below one and the size at most 256
   assign col0     = pu1_ff[FRAC_W +: CELL_W];
   assign row0     = pv1_ff[FRAC_W +: CELL_W];
   assign col0_inc = DIM_W'(col0) + DIM_W'(1);
   assign row0_inc = DIM_W'(row0) + DIM_W'(1);
   assign col1     = (col0_inc == dim_w) ? '0 : col0_inc[CELL_W-1:0];
   assign row1     = (row0_inc == dim_h) ? '0 : row0_inc[CELL_W-1:0];
   assign base0    = ROWB_W'(row0) * ROWB_W'(dim_w);
   assign base1    = ROWB_W'(row1) * ROWB_W'(dim_w);

   always_comb begin
      cmd2_in             = '0;
      cmd2_in.op          = op1_ff;
      cmd2_in.wr_addr     = idx1_ff;
      cmd2_in.wr_texel    = texel1_ff;
      cmd2_in.tap_addr[0] = ADDR_W'(base0 + ROWB_W'(col0));
      cmd2_in.tap_addr[1] = ADDR_W'(base0 + ROWB_W'(col1));
      cmd2_in.tap_addr[2] = ADDR_W'(base1 + ROWB_W'(col0));
      cmd2_in.tap_addr[3] = ADDR_W'(base1 + ROWB_W'(col1));
      cmd2_in.fu          = pu1_ff[FRAC_W-1:0];
      cmd2_in.fv          = pv1_ff[FRAC_W-1:0];
   end

   assign v2_in = v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         cmd2_ff <= cmd2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_cmd   = cmd2_ff;

endmodule

`default_nettype wire

@@ rtl/bwts_texel_ram.sv @@
// Texel store: two identical copies, each with one write port and two
// registered read ports, giving four neighbor reads per cycle. Uses bwts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bwts_texel_ram import bwts_pkg::*; (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [ADDR_W-1:0]                wr_addr,
   input  wire texel_type                        wr_data,
   input  wire logic                             rd_en,
   input  wire logic [NUM_TAPS-1:0][ADDR_W-1:0]  rd_addr,
   output texel_type [NUM_TAPS-1:0]              rd_data
);

   texel_type        bank_a_ff [MAX_TEXELS];
   texel_type        bank_b_ff [MAX_TEXELS];
   texel_type [1:0]  rd_a_ff;
   texel_type [1:0]  rd_b_ff;

   // copy A serves the top row of the footprint
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_a_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff[0] <= bank_a_ff[rd_addr[0]];
         rd_a_ff[1] <= bank_a_ff[rd_addr[1]];
      end
   end

   // copy B serves the bottom row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_b_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_b_ff[0] <= bank_b_ff[rd_addr[2]];
         rd_b_ff[1] <= bank_b_ff[rd_addr[3]];
      end
   end

   assign rd_data = {rd_b_ff, rd_a_ff};

endmodule

`default_nettype wire

@@ rtl/bwts_blend.sv @@
// Bilinear blend: horizontal lerp, vertical lerp, then channel mean into the
// output register. Three stages with per-stage flow control. Uses bwts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bwts_blend import bwts_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire texel_type [NUM_TAPS-1:0]  in_texel,
   input  wire logic [FRAC_W-1:0]         in_fu,
   input  wire logic [FRAC_W-1:0]         in_fv,
   output logic                           out_valid,
   input  wire logic                      out_stall,
   output logic [CHAN_W-1:0]              out_red,
   output logic [CHAN_W-1:0]              out_green,
   output logic [CHAN_W-1:0]              out_blue,
   output logic [CHAN_W-1:0]              out_mean
);

   localparam int unsigned HP_W   = CHAN_W + WGT_W;
   localparam int unsigned LERP_W = CHAN_W + FRAC_W;
   localparam int unsigned ACC_W  = LERP_W + WGT_W + 1;
   localparam int unsigned MP_W   = SUM_W + RECIP_W;

   typedef logic [NUM_CHAN-1:0][LERP_W-1:0] lerp_vec_type;

   logic               rdy4, rdy5, rdy6;
   logic [WGT_W-1:0]   wfu_n, wfv_n;

   // stage 4: row lerps
   logic               v4_ff;
   lerp_vec_type       top4_ff, top4_in;
   lerp_vec_type       bot4_ff, bot4_in;
   logic [FRAC_W-1:0]  fv4_ff;

   // stage 5: column lerp
   logic               v5_ff;
   texel_type          res5_ff, res5_in;
   logic [ACC_W-1:0]   acc [NUM_CHAN];

   // stage 6: output register
   logic               v6_ff;
   texel_type          res6_ff;
   logic [CHAN_W-1:0]  mean6_ff, mean6_in;
   logic [SUM_W-1:0]   chan_sum;
   logic [MP_W-1:0]    mean_prod;

   assign rdy6     = !v6_ff || !out_stall;
   assign rdy5     = !v5_ff || rdy6;
   assign rdy4     = !v4_ff || rdy5;
   assign in_ready = rdy4;

   assign wfu_n = WGT_ONE - WGT_W'(in_fu);
   assign wfv_n = WGT_ONE - WGT_W'(fv4_ff);

   // each row lerp stays below 2^32 since the weights sum to one
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         top4_in[c] = LERP_W'(HP_W'(in_texel[0][c]) * HP_W'(wfu_n)
                            + HP_W'(in_texel[1][c]) * HP_W'(in_fu));
         bot4_in[c] = LERP_W'(HP_W'(in_texel[2][c]) * HP_W'(wfu_n)
                            + HP_W'(in_texel[3][c]) * HP_W'(in_fu));
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         acc[c] = ACC_W'(top4_ff[c]) * ACC_W'(wfv_n)
                + ACC_W'(bot4_ff[c]) * ACC_W'(fv4_ff);
         res5_in[c] = acc[c][2*FRAC_W +: CHAN_W];
      end
   end

   assign chan_sum  = SUM_W'(res5_ff[0]) + SUM_W'(res5_ff[1]) + SUM_W'(res5_ff[2]);
   assign mean_prod = MP_W'(chan_sum) * MP_W'(ONE_THIRD_RECIP);
   assign mean6_in  = mean_prod[ONE_THIRD_SHIFT +: CHAN_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy4) begin
            v4_ff <= in_valid;
         end
         if (rdy5) begin
            v5_ff <= v4_ff;
         end
         if (rdy6) begin
            v6_ff <= v5_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         top4_ff <= top4_in;
         bot4_ff <= bot4_in;
         fv4_ff  <= in_fv;
      end
      if (rdy5) begin
         res5_ff <= res5_in;
      end
      if (rdy6) begin
         res6_ff  <= res5_ff;
         mean6_ff <= mean6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_red   = res6_ff[0];
   assign out_green = res6_ff[1];
   assign out_blue  = res6_ff[2];
   assign out_mean  = mean6_ff;

endmodule

`default_nettype wire

@@ rtl/bilinear_wrap_texture_sampler.sv @@
// Bilinear wrap-mode texture sampler, top level. Uses bwts_pkg, bwts_addr_gen,
// bwts_texel_ram and bwts_blend.
// Throughput: one request per cycle, writes and samples alike, unless rsp_stall
// holds the pipeline; the store keeps two copies with two read ports each, so all
// four neighbors are read at once.
// Reset: clears all pipeline valids and sets width and height to 1; texel contents
// are not cleared and read as garbage until written.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_wrap_texture_sampler import bwts_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_op,
   input  wire logic [ADDR_W-1:0]    req_texel_index,
   input  wire logic [CHAN_W-1:0]    req_red_in,
   input  wire logic [CHAN_W-1:0]    req_green_in,
   input  wire logic [CHAN_W-1:0]    req_blue_in,
   input  wire logic signed [31:0]   req_coord_u,
   input  wire logic signed [31:0]   req_coord_v,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [CHAN_W-1:0]         rsp_red_out,
   output logic [CHAN_W-1:0]         rsp_green_out,
   output logic [CHAN_W-1:0]         rsp_blue_out,
   output logic [CHAN_W-1:0]         rsp_mean_out,
   // configuration
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [PADDR_W-1:0]   paddr,
   input  wire logic [PDATA_W-1:0]   pwdata,
   output logic [PDATA_W-1:0]        prdata,
   output logic                      pready
);

   logic [DIM_W-1:0]       width_ff, width_in;
   logic [DIM_W-1:0]       height_ff, height_in;
   logic [DIM_W-1:0]       dim_w, dim_h;
   logic                   csr_wr;

   texel_type              req_texel;
   logic                   ag_ready;
   logic                   cmd_valid;
   samp_cmd_type           cmd;

   logic                   rdy3;
   logic                   v3_ff, v3_in;
   logic [FRAC_W-1:0]      fu3_ff, fv3_ff;
   logic                   ram_wr_en;
   texel_type [NUM_TAPS-1:0] taps;
   logic                   blend_ready;
   logic [2*DIM_W-1:0]     image_area;

   // ---------------- configuration registers ----------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         case (paddr[REG_SEL_BIT])
            REG_IDX_WIDTH:  width_in  = pwdata[DIM_W-1:0];
            REG_IDX_HEIGHT: height_in = pwdata[DIM_W-1:0];
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (paddr[REG_SEL_BIT])
         REG_IDX_WIDTH:  prdata = PDATA_W'(width_ff);
         REG_IDX_HEIGHT: prdata = PDATA_W'(height_ff);
         default:        prdata = '0;
      endcase
   end

   assign dim_w = clamp_dim(width_ff);
   assign dim_h = clamp_dim(height_ff);

   // ---------------- address generation ----------------
   assign req_texel = {req_blue_in, req_green_in, req_red_in};
   assign req_stall = !ag_ready;

   bwts_addr_gen u_addr_gen (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (ag_ready),
      .in_op     (req_op),
      .in_index  (req_texel_index),
      .in_texel  (req_texel),
      .in_u_frac (req_coord_u[FRAC_W-1:0]),
      .in_v_frac (req_coord_v[FRAC_W-1:0]),
      .dim_w     (dim_w),
      .dim_h     (dim_h),
      .out_valid (cmd_valid),
      .out_ready (rdy3),
      .out_cmd   (cmd)
   );

   // ---------------- texel store ----------------
   // Writes and reads both leave from the address stage in request order, so a
   // sample always reads after any earlier write has landed.
   assign rdy3      = !v3_ff || blend_ready;
   assign ram_wr_en = cmd_valid && (cmd.op == OP_WRITE) && rdy3;
   assign v3_in     = cmd_valid && (cmd.op == OP_SAMPLE);

   bwts_texel_ram u_texel_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cmd.wr_addr),
      .wr_data (cmd.wr_texel),
      .rd_en   (rdy3),
      .rd_addr (cmd.tap_addr),
      .rd_data (taps)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         fu3_ff <= cmd.fu;
         fv3_ff <= cmd.fv;
      end
   end

   // ---------------- filtering ----------------
   bwts_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3_ff),
      .in_ready  (blend_ready),
      .in_texel  (taps),
      .in_fu     (fu3_ff),
      .in_fv     (fv3_ff),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_red   (rsp_red_out),
      .out_green (rsp_green_out),
      .out_blue  (rsp_blue_out),
      .out_mean  (rsp_mean_out)
   );

   // ---------------- checks ----------------
   assign image_area = (2*DIM_W)'(dim_w) * (2*DIM_W)'(dim_h);

   // input backs up only when every stage is full and the output is held
   a_stall_needs_full_pipe: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while pipeline has room");

   a_taps_inside_image: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && (cmd.op == OP_SAMPLE)) |->
         (((2*DIM_W)'(cmd.tap_addr[0]) < image_area) &&
          ((2*DIM_W)'(cmd.tap_addr[3]) < image_area)))
      else $error("sample footprint outside the image");

   a_mean_not_above_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_mean_out <= rsp_red_out) || (rsp_mean_out <= rsp_green_out) ||
                     (rsp_mean_out <= rsp_blue_out)))
      else $error("channel mean exceeds every channel");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for bilinear_wrap_texture_sampler: texel writes, wrapped bilinear samples,
// image size register writes. Depends on bwts_pkg and the sampler RTL only.
`timescale 1ns / 1ps

module tb_top import bwts_pkg::*; ();

   localparam int unsigned SETTLE_CYCLES = 12;   // pipeline is 6 deep
   localparam logic [PADDR_W-1:0] WIDTH_REG_ADDR  = PADDR_W'(REG_IDX_WIDTH) << REG_SEL_BIT;
   localparam logic [PADDR_W-1:0] HEIGHT_REG_ADDR = PADDR_W'(REG_IDX_HEIGHT) << REG_SEL_BIT;

   typedef struct packed {
      logic                 hold_for_drain;   // wait for all pixels back before sending
      logic                 op;
      logic [ADDR_W-1:0]    texel_index;
      logic [CHAN_W-1:0]    red;
      logic [CHAN_W-1:0]    green;
      logic [CHAN_W-1:0]    blue;
      logic [31:0]          coord_u;
      logic [31:0]          coord_v;
   } tex_request_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] mean;
   } filtered_pixel_type;

   typedef struct packed {
      logic [NUM_TAPS-1:0][ADDR_W-1:0] addr;   // r0c0, r0c1, r1c0, r1c1
      logic [FRAC_W-1:0]               fu;
      logic [FRAC_W-1:0]               fv;
   } tap_set_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_op = OP_WRITE;
   logic [ADDR_W-1:0]   req_texel_index = '0;
   logic [CHAN_W-1:0]   req_red_in = '0;
   logic [CHAN_W-1:0]   req_green_in = '0;
   logic [CHAN_W-1:0]   req_blue_in = '0;
   logic signed [31:0]  req_coord_u = '0;
   logic signed [31:0]  req_coord_v = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CHAN_W-1:0]   rsp_red_out;
   logic [CHAN_W-1:0]   rsp_green_out;
   logic [CHAN_W-1:0]   rsp_blue_out;
   logic [CHAN_W-1:0]   rsp_mean_out;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [PDATA_W-1:0]  pwdata = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   // model state: texel store mirror ({blue, green, red}) and size registers
   logic [NUM_CHAN*CHAN_W-1:0] texel_image [MAX_TEXELS];
   logic [DIM_W-1:0]           image_width_cfg = DIM_W'(1);
   logic [DIM_W-1:0]           image_height_cfg = DIM_W'(1);

   bit                   texel_loaded [MAX_TEXELS];   // written by some queued request
   tex_request_type      pending_requests[$];
   filtered_pixel_type   expected_pixels[$];
   tex_request_type      active_request;
   tex_request_type      next_request;
   filtered_pixel_type   want;
   logic                 request_loaded = 1'b0;

   int unsigned send_idle_pct = 7;
   int unsigned recv_stall_pct = 75;
   int unsigned queued_items = 0;
   int unsigned writes_seen = 0;
   int unsigned samples_checked = 0;
   int unsigned sizes_tried = 0;
   int unsigned error_count = 0;

   bilinear_wrap_texture_sampler DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_texel_index (req_texel_index),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_coord_u     (req_coord_u),
      .req_coord_v     (req_coord_v),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_mean_out    (rsp_mean_out),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial forever #2 clock = ~clock;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic int unsigned effective_dim(input logic [DIM_W-1:0] d);
      int unsigned r;
      if (d == '0) begin
         r = 1;
      end else if (d > 256) begin
         r = 256;
      end else begin
         r = 32'(d);
      end
      return r;
   endfunction

   function automatic tap_set_type locate_taps(input logic [31:0] u, input logic [31:0] v);
      tap_set_type       ts;
      logic [FRAC_W-1:0] uf, vf;
      int unsigned       w, h, pu, pv, col0, row0, col1, row1;
      w  = effective_dim(image_width_cfg);
      h  = effective_dim(image_height_cfg);
      uf = u[15:0];
      vf = 16'h0000 - v[15:0];   // frac(1 - v), negatives wrap
      pu = uf * w;
      pv = vf * h;
      col0 = pu >> 16;
      row0 = pv >> 16;
      col1 = (col0 + 1) % w;
      row1 = (row0 + 1) % h;
      ts.fu = pu[15:0];
      ts.fv = pv[15:0];
      ts.addr[0] = ADDR_W'(row0 * w + col0);
      ts.addr[1] = ADDR_W'(row0 * w + col1);
      ts.addr[2] = ADDR_W'(row1 * w + col0);
      ts.addr[3] = ADDR_W'(row1 * w + col1);
      return ts;
   endfunction

   function automatic filtered_pixel_type filter_sample(input tex_request_type rq);
      tap_set_type                     ts;
      logic [NUM_TAPS-1:0][33:0]       wgt;
      logic [NUM_CHAN-1:0][CHAN_W-1:0] chan;
      longint unsigned                 acc;
      int unsigned                     sum;
      filtered_pixel_type              px;
      ts = locate_taps(rq.coord_u, rq.coord_v);
      wgt[0] = (34'h10000 - ts.fu) * (34'h10000 - ts.fv);
      wgt[1] = ts.fu * (34'h10000 - ts.fv);
      wgt[2] = (34'h10000 - ts.fu) * ts.fv;
      wgt[3] = ts.fu * ts.fv;
      for (int c = 0; c < NUM_CHAN; c++) begin
         acc = 0;
         for (int k = 0; k < NUM_TAPS; k++)
            acc += 64'(texel_image[ts.addr[k]][c*CHAN_W +: CHAN_W]) * 64'(wgt[k]);
         // weights sum to exactly one, so the result never exceeds 16 bits
         chan[c] = CHAN_W'(acc >> 32);
      end
      sum = 32'(chan[0]) + 32'(chan[1]) + 32'(chan[2]);
      px.red   = chan[0];
      px.green = chan[1];
      px.blue  = chan[2];
      px.mean  = CHAN_W'(sum / 3);
      return px;
   endfunction

   // write updates the store mirror, sample queues the pixel it must produce
   function automatic void mirror_request(input tex_request_type rq);
      if (rq.op == OP_WRITE) begin
         texel_image[rq.texel_index] = {rq.blue, rq.green, rq.red};
         writes_seen++;
      end else begin
         expected_pixels.push_back(filter_sample(rq));
      end
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         request_loaded = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            mirror_request(active_request);
            request_loaded = 1'b0;
         end
         if (!request_loaded && pending_requests.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            next_request = pending_requests[0];
            if (!next_request.hold_for_drain || expected_pixels.size() == 0) begin
               active_request = pending_requests.pop_front();
               request_loaded = 1'b1;
               req_op          <= active_request.op;
               req_texel_index <= active_request.texel_index;
               req_red_in      <= active_request.red;
               req_green_in    <= active_request.green;
               req_blue_in     <= active_request.blue;
               req_coord_u     <= active_request.coord_u;
               req_coord_v     <= active_request.coord_v;
            end
         end
         req_valid <= request_loaded;
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_channel(input string name, input logic [CHAN_W-1:0] exp_val,
                                input logic [CHAN_W-1:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s mismatch: expected %h, got %h", name, exp_val, got_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result: red %h green %h blue %h mean %h",
                      rsp_red_out, rsp_green_out, rsp_blue_out, rsp_mean_out);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_channel("red_out", want.red, rsp_red_out);
               check_channel("green_out", want.green, rsp_green_out);
               check_channel("blue_out", want.blue, rsp_blue_out);
               check_channel("mean_out", want.mean, rsp_mean_out);
               samples_checked++;
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic [CHAN_W-1:0] rand_channel();
      logic [CHAN_W-1:0] v;
      case ($urandom_range(7))
         0:       v = '0;
         1:       v = '1;
         default: v = CHAN_W'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [31:0] rand_coord();
      logic [31:0] c;
      case ($urandom_range(4))
         0: c = {16'($urandom), 16'h0000};               // whole units, zero fraction
         1: c = {16'($urandom), 8'hFF, 8'($urandom)};    // just short of the next unit
         2: begin
            c = 32'($urandom_range(32'h3FFFF));
            if ($urandom_range(1) == 1) c = -c;
         end
         default: c = $urandom;
      endcase
      return c;
   endfunction

   task automatic queue_write(input logic [ADDR_W-1:0] idx, input logic [CHAN_W-1:0] r,
                              input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
      tex_request_type rq;
      rq.hold_for_drain = 1'b0;
      rq.op          = OP_WRITE;
      rq.texel_index = idx;
      rq.red         = r;
      rq.green       = g;
      rq.blue        = b;
      rq.coord_u     = $urandom;
      rq.coord_v     = $urandom;
      texel_loaded[idx] = 1'b1;
      pending_requests.push_back(rq);
      queued_items++;
   endtask

   // any neighbor not yet written gets a write first, so no sample reads garbage
   task automatic queue_sample(input logic [31:0] u, input logic [31:0] v, input bit hold);
      tap_set_type     ts;
      tex_request_type rq;
      ts = locate_taps(u, v);
      for (int k = 0; k < NUM_TAPS; k++)
         if (!texel_loaded[ts.addr[k]])
            queue_write(ts.addr[k], rand_channel(), rand_channel(), rand_channel());
      rq.hold_for_drain = hold;
      rq.op          = OP_SAMPLE;
      rq.texel_index = ADDR_W'($urandom);
      rq.red         = CHAN_W'($urandom);
      rq.green       = CHAN_W'($urandom);
      rq.blue        = CHAN_W'($urandom);
      rq.coord_u     = u;
      rq.coord_v     = v;
      pending_requests.push_back(rq);
      queued_items++;
   endtask

   task automatic queue_random(input int unsigned count);
      int unsigned stop_at, span;
      stop_at = queued_items + count;
      span = effective_dim(image_width_cfg) * effective_dim(image_height_cfg);
      while (queued_items < stop_at) begin
         if ($urandom_range(99) < 25) begin
            if ($urandom_range(1) == 1)
               queue_write(ADDR_W'($urandom), rand_channel(), rand_channel(), rand_channel());
            else
               queue_write(ADDR_W'($urandom_range(span - 1)), rand_channel(),
                           rand_channel(), rand_channel());
         end else begin
            queue_sample(rand_coord(), rand_coord(), $urandom_range(49) == 0);
         end
      end
   endtask

   task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [DIM_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= PDATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_image_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      write_reg(WIDTH_REG_ADDR, w);
      image_width_cfg = w;
      write_reg(HEIGHT_REG_ADDR, h);
      image_height_cfg = h;
      sizes_tried++;
   endtask

   // all requests taken, all pixels back, then let the pipe empty of writes
   task automatic wait_idle();
      while (pending_requests.size() != 0 || request_loaded || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      set_image_size(w, h);
      queue_random(105);
      wait_idle();
   endtask

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);

      // reset size 1x1: every tap lands on texel 0
      queue_write(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
      queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      queue_write(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
      queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      queue_write(16'h0000, 16'h0000, 16'hFFFF, 16'h8001);
      queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      queue_sample(32'h0000_8000, 32'hFFFF_8000, 1'b0);
      queue_random(90);
      wait_idle();

      // largest image: wrap at right and bottom edges, overwrite then read back
      set_image_size(9'd256, 9'd256);
      queue_sample(32'h0000_FFFF, 32'h0000_0001, 1'b0);
      queue_sample(32'h0001_0000, 32'h0001_0000, 1'b0);
      queue_sample(32'h0000_0100, 32'h0000_FF00, 1'b0);
      queue_write(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_sample(32'h0000_0000, 32'h0000_0000, 1'b1);
      queue_sample(32'hFFFF_0080, 32'h8000_0080, 1'b0);
      queue_random(100);
      wait_idle();

      random_phase(9'd0, 9'd0);          // zero reads as one

      send_idle_pct  = 75;
      recv_stall_pct = 7;
      random_phase(9'd511, 9'd257);      // above the maximum reads as 256
      random_phase(9'd3, 9'd7);
      random_phase(DIM_W'($urandom_range(1, 256)), DIM_W'($urandom_range(1, 256)));

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_phase(9'd1, 9'd200);
      random_phase(9'd255, 9'd2);

      $display("Covered %0d texel writes and %0d checked samples", writes_seen,
               samples_checked);
      $display("across %0d image sizes, 1x1 to 256x256 plus out-of-range values",
               sizes_tried + 1);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d requests pending, %0d pixels outstanding",
               pending_requests.size(), expected_pixels.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
